[src/dsgd_pkg.sv]
// dsgd_pkg: shared types and constants for the symbol group deglitcher
// used by dsgd_front, dsgd_queue, dsgd_back and the top level; no dependencies
package dsgd_pkg;

    localparam int DATA_W     = 64;
    localparam int CNT_W      = 5;
    localparam int CODE_W     = 4;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 5;

    localparam int DEF_MAX_CHANNELS = 16;
    localparam int DEF_SYMBOL_BITS  = 4;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [CNT_W-1:0]  RESET_CHANNEL_COUNT = 5'd2;
    localparam logic [CODE_W-1:0] RESET_UNKNOWN_CODE  = 4'd15;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_CODE  = 4'd1;

    localparam logic OP_SLOT = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_LATE    = 2'd0,
        KIND_CURRENT = 2'd1,
        KIND_FILLER  = 2'd2
    } kind_t;

    typedef enum logic {
        PH_FIRST  = 1'b0,
        PH_SECOND = 1'b1
    } phase_t;

    typedef struct packed {
        logic [DATA_W-1:0] main_group;
        logic [DATA_W-1:0] prev_group;
        logic              main_filler;
        logic              emit_late;
        logic              sep;
    } dsgd_cmd_t;

endpackage

[src/dsgd_front.sv]
// dsgd_front: configuration registers, slot classification and stream state
// depends on dsgd_pkg; pushes one command per slot that produces results
module dsgd_front #(
    parameter int MAX_CHANNELS = dsgd_pkg::DEF_MAX_CHANNELS,
    parameter int SYMBOL_BITS  = dsgd_pkg::DEF_SYMBOL_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dsgd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dsgd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             slot_valid,
    output logic                             slot_stall,
    input  logic                             op,
    input  logic [dsgd_pkg::DATA_W-1:0]      symbols,
    input  logic                             q_full,
    output logic                             push,
    output dsgd_pkg::dsgd_cmd_t              push_cmd
);
    import dsgd_pkg::*;

    localparam int LANES_FIT = DATA_W / SYMBOL_BITS;
    localparam int LANES = (MAX_CHANNELS < LANES_FIT) ? MAX_CHANNELS : LANES_FIT;

    logic [CNT_W-1:0]       channel_count_reg;
    logic [CODE_W-1:0]      unknown_code_reg;
    logic [DATA_W-1:0]      prev_group_reg;
    logic [DATA_W-1:0]      prev_group_next;
    logic                   prev_valid_reg;
    logic                   prev_valid_next;
    logic                   late_reg;
    logic                   late_next;
    logic                   any_emitted_reg;
    logic                   any_emitted_next;

    logic                   accept;
    logic [SYMBOL_BITS-1:0] unk_lane;
    logic [LANES-1:0]       active;
    logic [LANES-1:0]       rep;
    logic [LANES-1:0]       is_unk;
    logic [DATA_W-1:0]      cur_group;
    logic [DATA_W-1:0]      prev_masked;
    logic [DATA_W-1:0]      filler_group;
    logic                   all_same;
    logic                   all_unk;
    logic                   any_unk;
    logic                   any_same;

    assign cfg_ready  = 1'b1;
    assign slot_stall = q_full;
    assign accept     = slot_valid && !slot_stall;
    assign unk_lane   = SYMBOL_BITS'(unknown_code_reg);

    // per-lane compare against the last emitted group
    for (genvar i = 0; i < LANES; i++) begin : g_lane
        logic [SYMBOL_BITS-1:0] sym_lane;
        assign sym_lane  = symbols[i*SYMBOL_BITS +: SYMBOL_BITS];
        assign active[i] = (CNT_W'(i) < channel_count_reg);
        assign rep[i]    = prev_valid_reg
                           && (sym_lane == prev_group_reg[i*SYMBOL_BITS +: SYMBOL_BITS]);
        assign is_unk[i] = (sym_lane == unk_lane);
        assign cur_group[i*SYMBOL_BITS +: SYMBOL_BITS] =
            active[i] ? sym_lane : '0;
        assign prev_masked[i*SYMBOL_BITS +: SYMBOL_BITS] =
            active[i] ? prev_group_reg[i*SYMBOL_BITS +: SYMBOL_BITS] : '0;
        assign filler_group[i*SYMBOL_BITS +: SYMBOL_BITS] =
            active[i] ? unk_lane : '0;
    end

    if (LANES * SYMBOL_BITS < DATA_W) begin : g_pad
        assign cur_group[DATA_W-1:LANES*SYMBOL_BITS]    = '0;
        assign prev_masked[DATA_W-1:LANES*SYMBOL_BITS]  = '0;
        assign filler_group[DATA_W-1:LANES*SYMBOL_BITS] = '0;
    end

    assign all_same = &(rep | ~active);
    assign all_unk  = &(is_unk | ~active);
    assign any_unk  = |(is_unk & active);
    assign any_same = |(rep & active);

    always_comb
    begin
        prev_group_next      = prev_group_reg;
        prev_valid_next      = prev_valid_reg;
        late_next            = late_reg;
        any_emitted_next     = any_emitted_reg;
        push                 = 1'b0;
        push_cmd.main_group  = cur_group;
        push_cmd.prev_group  = prev_masked;
        push_cmd.main_filler = 1'b0;
        push_cmd.emit_late   = 1'b0;
        push_cmd.sep         = any_emitted_reg;
        if (accept)
        begin
            priority if (op == OP_END)
            begin
                push_cmd.main_group  = filler_group;
                push_cmd.main_filler = 1'b1;
                push_cmd.sep         = 1'b0;
                push                 = !any_emitted_reg;
                prev_valid_next      = 1'b0;
                late_next            = 1'b0;
                any_emitted_next     = 1'b0;
            end
            else if (all_same || all_unk)
            begin
                push = 1'b0;
            end
            else if (any_unk)
            begin
                if (!any_same)
                begin
                    late_next = 1'b1;
                end
            end
            else
            begin
                push               = 1'b1;
                push_cmd.emit_late = late_reg && any_same;
                prev_group_next    = cur_group;
                prev_valid_next    = 1'b1;
                late_next          = 1'b0;
                any_emitted_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= RESET_CHANNEL_COUNT;
            unknown_code_reg  <= RESET_UNKNOWN_CODE;
            prev_valid_reg    <= 1'b0;
            late_reg          <= 1'b0;
            any_emitted_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_CHANNEL_COUNT: channel_count_reg <= cfg_data;
                    REG_UNKNOWN_CODE:  unknown_code_reg  <= cfg_data[CODE_W-1:0];
                    default:           ;
                endcase
            end
            prev_valid_reg  <= prev_valid_next;
            late_reg        <= late_next;
            any_emitted_reg <= any_emitted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_group_reg <= prev_group_next;
    end

endmodule

[src/dsgd_queue.sv]
// dsgd_queue: short command queue between front and back
// depends on dsgd_pkg for the command type and depth
module dsgd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  dsgd_pkg::dsgd_cmd_t push_cmd,
    input  logic                pop,
    output logic                full,
    output logic                empty,
    output dsgd_pkg::dsgd_cmd_t head
);
    import dsgd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(QUEUE_DEPTH);

    dsgd_cmd_t         entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_QW-1:0] count_reg;
    logic [CNT_QW-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[src/dsgd_back.sv]
// dsgd_back: expands queued commands into one or two result transactions
// depends on dsgd_pkg; drives the registered result channel
module dsgd_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  dsgd_pkg::dsgd_cmd_t          head,
    output logic                         pop,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [dsgd_pkg::DATA_W-1:0]  group,
    output logic [dsgd_pkg::KIND_W-1:0]  kind,
    output logic                         separator_before,
    output logic                         last
);
    import dsgd_pkg::*;

    phase_t            phase_reg;
    phase_t            phase_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] group_reg;
    kind_t             kind_reg;
    logic              sep_reg;
    logic              last_reg;

    logic              load;
    logic              late_sel;
    logic [DATA_W-1:0] res_group;
    kind_t             res_kind;
    logic              res_sep;

    assign load = !q_empty && (!out_valid_reg || !result_stall);

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_FIRST:
            begin
                if (load && head.emit_late)
                begin
                    phase_next = PH_SECOND;
                end
            end
            PH_SECOND:
            begin
                if (load)
                begin
                    phase_next = PH_FIRST;
                end
            end
            default: phase_next = PH_FIRST;
        endcase
    end

    always_comb
    begin
        late_sel  = 1'b0;
        res_sep   = 1'b0;
        unique case (phase_reg)
            PH_FIRST:
            begin
                late_sel = head.emit_late;
                res_sep  = head.sep;
            end
            PH_SECOND:
            begin
                late_sel = 1'b0;
                res_sep  = 1'b0;
            end
            default:
            begin
                late_sel = 1'b0;
                res_sep  = 1'b0;
            end
        endcase
        res_group = late_sel ? head.prev_group : head.main_group;
        priority if (late_sel)
        begin
            res_kind = KIND_LATE;
        end
        else if (head.main_filler)
        begin
            res_kind = KIND_FILLER;
        end
        else
        begin
            res_kind = KIND_CURRENT;
        end
        pop = load && !late_sel;
    end

    assign out_valid_next = load || (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            group_reg <= res_group;
            kind_reg  <= res_kind;
            sep_reg   <= res_sep;
            last_reg  <= !late_sel;
        end
    end

    assign result_valid     = out_valid_reg;
    assign group            = group_reg;
    assign kind             = kind_reg;
    assign separator_before = sep_reg;
    assign last             = last_reg;

endmodule

[src/dtmf_symbol_group_deglitcher_top.sv]
// Symbol group deglitcher. Each slot transaction carries one symbol code per channel lane;
// the front classifies a slot in the cycle it is taken and updates the stream state, so a
// new slot is taken every cycle while the command queue has room. The back turns each
// queued command into one or two result transactions, one per cycle while result_stall
// is low, through a single registered output: a slot that confirms a late group gives
// its late group first and then its current group, and any other slot that emits gives
// one result. End of stream emits a filler group only if the stream produced nothing,
// and then starts a fresh stream; configuration is kept.
// depends on dsgd_pkg, dsgd_front, dsgd_queue, dsgd_back
module dtmf_symbol_group_deglitcher_top #(
    parameter int MAX_CHANNELS = dsgd_pkg::DEF_MAX_CHANNELS,
    parameter int SYMBOL_BITS  = dsgd_pkg::DEF_SYMBOL_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dsgd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dsgd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             slot_valid,
    output logic                             slot_stall,
    input  logic                             op,
    input  logic [dsgd_pkg::DATA_W-1:0]      symbols,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [dsgd_pkg::DATA_W-1:0]      group,
    output logic [dsgd_pkg::KIND_W-1:0]      kind,
    output logic                             separator_before,
    output logic                             last
);
    import dsgd_pkg::*;

    logic      push;
    dsgd_cmd_t push_cmd;
    logic      pop;
    logic      q_full;
    logic      q_empty;
    dsgd_cmd_t head;

    dsgd_front #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SYMBOL_BITS  (SYMBOL_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .slot_valid (slot_valid),
        .slot_stall (slot_stall),
        .op         (op),
        .symbols    (symbols),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    dsgd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head)
    );

    dsgd_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .head             (head),
        .pop              (pop),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .group            (group),
        .kind             (kind),
        .separator_before (separator_before),
        .last             (last)
    );

endmodule
